/* rtl/assert_macros.svh */
// Assertion macros shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication, disabled during reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/fbvt_pkg.sv */
//------------------------------------------------------------------------------
// fbvt_pkg
// Shared types and constants for the frustum box visibility test.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package fbvt_pkg;
   localparam int NumWords  = 37;
   localparam int PlaneBase = 6;
   localparam int VertBase  = 22;
   localparam int NumPlanes = 4;
   localparam int NumVerts  = 5;
   localparam int NumCorner = 8;

   localparam logic [1:0] VIS_OUTSIDE  = 2'd0;
   localparam logic [1:0] VIS_STRADDLE = 2'd1;
   localparam logic [1:0] VIS_INSIDE   = 2'd2;

   localparam logic OP_TEST = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   typedef logic signed [31:0] word_type;
   typedef word_type box_type [6];
endpackage

/* rtl/fbvt_table.sv */
//------------------------------------------------------------------------------
// fbvt_table
// Frustum word store; every word is read at a fixed place by the datapath.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module fbvt_table
   import fbvt_pkg::*;
(
   input  logic           clock,
   input  logic           wr_en,
   input  logic [5:0]     wr_index,
   input  word_type       wr_value,
   output word_type       words [NumWords]
);
   word_type table_ff [NumWords];

   always_ff @(posedge clock) begin
      if (wr_en && wr_index < 6'(NumWords)) begin
         table_ff[wr_index] <= wr_value;
      end
   end

   assign words = table_ff;
endmodule

/* rtl/fbvt_plane.sv */
//------------------------------------------------------------------------------
// fbvt_plane
// Three-stage plane test of one corner: multiply, sum, sign.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module fbvt_plane
   import fbvt_pkg::*;
(
   input  logic     clock,
   input  word_type nx, ny, nz, dd,
   input  word_type cx, cy, cz,
   output logic     outside
);
   logic signed [63:0] px_ff, py_ff, pz_ff, pd_ff;
   logic signed [65:0] sum_ff;
   logic               outside_ff;

   always_ff @(posedge clock) begin
      px_ff <= nx * cx;
      py_ff <= ny * cy;
      pz_ff <= nz * cz;
      pd_ff <= 64'(dd) <<< 14;
      sum_ff <= 66'(px_ff) + 66'(py_ff) + 66'(pz_ff) - 66'(pd_ff);
      outside_ff <= !sum_ff[65] && (sum_ff != '0);
   end
   assign outside = outside_ff;
endmodule

/* rtl/frustum_box_visibility_test_top.sv */
// A box word's result passes through v0_ff, the three v_ff stages and strobe_ff.
// Throughput: one word per cycle; busy is tied low.
// Loads give no result and take effect for boxes accepted from the next cycle.
// Reset (synchronous, active high) clears the pipeline valid bits only;
// the frustum store is undefined until loaded. The receiver cannot stall.
`timescale 1ns / 1ps
module frustum_box_visibility_test_top
   import fbvt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [5:0]  req_word_index,
   input  word_type    req_word_value,
   input  word_type    req_box_x_min, req_box_x_max,
   input  word_type    req_box_y_min, req_box_y_max,
   input  word_type    req_box_z_min, req_box_z_max,
   input  logic        req_reverse_test,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_visibility
);
   word_type words [NumWords];
   logic     accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Store frustum words from load commands.
   fbvt_table u_table (
      .clock, .wr_en(accept && req_op == OP_LOAD),
      .wr_index(req_word_index), .wr_value(req_word_value), .words
   );

   // Stage 0: register the box and evaluate bound and reverse-vertex tests.
   logic     v0_ff, rev0_ff, bmiss0_ff, vcull0_ff;
   word_type b0_ff [6];
   logic     bmiss_in, vcull_in;
   logic [5:0] common_in;
   word_type bx [6];
   assign bx = '{req_box_x_min, req_box_x_max, req_box_y_min,
                 req_box_y_max, req_box_z_min, req_box_z_max};

   always_comb begin
      bmiss_in = words[1] < bx[0] || words[3] < bx[2] || words[5] < bx[4] ||
                 words[0] > bx[1] || words[2] > bx[3] || words[4] > bx[5];
      common_in = 6'h3f;
      for (int v = 0; v < NumVerts; v++) begin
         common_in &= {words[VertBase+3*v+2] >= bx[5], words[VertBase+3*v+2] <= bx[4],
                       words[VertBase+3*v+1] <= bx[2], words[VertBase+3*v+1] >= bx[3],
                       words[VertBase+3*v]   >= bx[1], words[VertBase+3*v]   <= bx[0]};
      end
      vcull_in = common_in != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= accept && req_op == OP_TEST;
      end
      b0_ff     <= bx;
      rev0_ff   <= req_reverse_test;
      bmiss0_ff <= bmiss_in;
      vcull0_ff <= vcull_in;
   end

   // Stages 1-3: corner-by-plane tests, 32 in parallel.
   logic outs [NumCorner][NumPlanes];
   for (genvar c = 0; c < NumCorner; c++) begin : g_corner
      for (genvar p = 0; p < NumPlanes; p++) begin : g_plane
         fbvt_plane u_plane (
            .clock,
            .nx(words[PlaneBase+4*p]), .ny(words[PlaneBase+4*p+1]),
            .nz(words[PlaneBase+4*p+2]), .dd(words[PlaneBase+4*p+3]),
            .cx(b0_ff[(c & 1) != 0 ? 1 : 0]), .cy(b0_ff[(c & 2) != 0 ? 3 : 2]),
            .cz(b0_ff[(c & 4) != 0 ? 5 : 4]), .outside(outs[c][p])
         );
      end
   end

   // Carry the side flags alongside the plane pipeline.
   logic [2:0] v_ff;
   logic [2:0] rev_ff, bmiss_ff, vcull_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], v0_ff};
      end
      rev_ff   <= {rev_ff[1:0], rev0_ff};
      bmiss_ff <= {bmiss_ff[1:0], bmiss0_ff};
      vcull_ff <= {vcull_ff[1:0], vcull0_ff};
   end

   // Final decision.
   logic [1:0] vis_in;
   logic       any_out, com_out;
   always_comb begin
      any_out = 1'b0;
      com_out = 1'b0;
      for (int p = 0; p < NumPlanes; p++) begin
         logic all_c;
         all_c = 1'b1;
         for (int c = 0; c < NumCorner; c++) begin
            all_c &= outs[c][p];
            any_out |= outs[c][p];
         end
         com_out |= all_c;
      end
      if (bmiss_ff[2])                   vis_in = VIS_OUTSIDE;
      else if (!any_out)                 vis_in = VIS_INSIDE;
      else if (com_out)                  vis_in = VIS_OUTSIDE;
      else if (rev_ff[2] && vcull_ff[2]) vis_in = VIS_OUTSIDE;
      else                               vis_in = VIS_STRADDLE;
   end

   logic       strobe_ff;
   logic [1:0] vis_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= v_ff[2];
      end
      vis_ff <= vis_in;
   end
   assign rsp_strobe     = strobe_ff;
   assign rsp_visibility = vis_ff;
endmodule

/* rtl/fbvt_checker.sv */
//------------------------------------------------------------------------------
// fbvt_checker
// Port-level checks of the visibility test, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fbvt_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_op,
   input logic       rsp_strobe,
   input logic [1:0] rsp_visibility
);
   `CHK_IMPL(a_vis_code, clock, reset, rsp_strobe, rsp_visibility != 2'd3, "bad code")
   `CHK_NEXT(a_no_busy, clock, reset, 1'b1, !busy, "busy raised")
   `CHK_IMPL(a_strobe_src, clock, reset, rsp_strobe, $past(start && !req_op, 5), "stray result")
   `CHK_IMPL(a_load_quiet, clock, reset, $past(start && req_op, 5), !rsp_strobe, "load result")
endmodule

bind frustum_box_visibility_test_top fbvt_checker u_fbvt_checker (
   .clock, .reset, .start, .busy, .req_op, .rsp_strobe, .rsp_visibility
);

/* bench/fbvt_checker.sv */
//------------------------------------------------------------------------------
// fbvt_scoreboard
// Watches the request and response channels of the frustum box visibility
// test, keeps its own frustum store, predicts the class of every box and
// compares each response with the oldest prediction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module fbvt_scoreboard
   import fbvt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_op,
   input  logic [5:0]  req_word_index,
   input  word_type    req_word_value,
   input  word_type    req_box_x_min, req_box_x_max,
   input  word_type    req_box_y_min, req_box_y_max,
   input  word_type    req_box_z_min, req_box_z_max,
   input  logic        req_reverse_test,
   input  logic        rsp_strobe,
   input  logic [1:0]  rsp_visibility,
   output int          fail_count,
   output int          pending,
   output int          box_count
);
   word_type   frustum_words [NumWords];
   logic [1:0] expected_class [$];

   assign pending = expected_class.size();

   // true when the point lies strictly outside plane p
   function automatic bit beyond_plane(int p, word_type x, word_type y, word_type z);
      logic signed [127:0] acc;
      int b;
      b = PlaneBase + 4 * p;
      acc = 128'(frustum_words[b] * 64'(x)) + 128'(frustum_words[b+1] * 64'(y))
          + 128'(frustum_words[b+2] * 64'(z)) - 128'(64'(frustum_words[b+3]) * 16384);
      return acc > 0;
   endfunction

   function automatic logic [1:0] classify_box(box_type bx, logic rev);
      logic [5:0] common, any, flags;
      word_type   cx, cy, cz, vx, vy, vz;
      int         v;
      if (frustum_words[1] < bx[0] || frustum_words[3] < bx[2] ||
          frustum_words[5] < bx[4] || frustum_words[0] > bx[1] ||
          frustum_words[2] > bx[3] || frustum_words[4] > bx[5])
         return VIS_OUTSIDE;
      common = '1;
      any    = '0;
      for (int c = 0; c < NumCorner; c++) begin
         cx = c[0] ? bx[1] : bx[0];
         cy = c[1] ? bx[3] : bx[2];
         cz = c[2] ? bx[5] : bx[4];
         flags = '0;
         for (int p = 0; p < NumPlanes; p++)
            flags[p] = beyond_plane(p, cx, cy, cz);
         common &= flags;
         any    |= flags;
      end
      if (any == 0) return VIS_INSIDE;
      if (common != 0) return VIS_OUTSIDE;
      if (!rev) return VIS_STRADDLE;
      common = '1;
      for (v = 0; v < NumVerts; v++) begin
         vx = frustum_words[VertBase + 3*v];
         vy = frustum_words[VertBase + 3*v + 1];
         vz = frustum_words[VertBase + 3*v + 2];
         flags = {vz >= bx[5], vz <= bx[4], vy >= bx[3], vy <= bx[2],
                  vx >= bx[1], vx <= bx[0]};
         common &= flags;
      end
      return (common != 0) ? VIS_OUTSIDE : VIS_STRADDLE;
   endfunction

   always @(posedge clock) begin
      box_type    bx;
      logic [1:0] want;
      if (reset) begin
         expected_class.delete();
         fail_count <= 0;
         box_count  <= 0;
         for (int i = 0; i < NumWords; i++) frustum_words[i] = '0;
      end else begin
         // compare first: a load in this cycle only affects later boxes
         if (rsp_strobe) begin
            if (expected_class.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response %0d with none expected", $time, rsp_visibility);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_class.pop_front();
               if (want !== rsp_visibility) begin
                  if (fail_count < 10)
                     $display("%0t: visibility expected %0d got %0d",
                              $time, want, rsp_visibility);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            if (req_op == OP_LOAD) begin
               if (req_word_index < NumWords)
                  frustum_words[req_word_index] = req_word_value;
            end else begin
               bx = '{req_box_x_min, req_box_x_max, req_box_y_min,
                      req_box_y_max, req_box_z_min, req_box_z_max};
               expected_class.push_back(classify_box(bx, req_reverse_test));
               box_count <= box_count + 1;
            end
         end
      end
   end
endmodule

/* bench/tb_frustum_box_visibility_test_top.sv */
//------------------------------------------------------------------------------
// tb_frustum_box_visibility_test_top
// Drives load and box words into the frustum box visibility test under
// several idling phases; the scoreboard beside the block predicts and compares.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_frustum_box_visibility_test_top;
   import fbvt_pkg::*;

   localparam int WatchdogLimit = 2000;

   logic       clock, reset, start, busy, req_op, req_reverse_test;
   logic [5:0] req_word_index;
   word_type   req_word_value;
   word_type   req_box_x_min, req_box_x_max, req_box_y_min;
   word_type   req_box_y_max, req_box_z_min, req_box_z_max;
   logic       rsp_strobe;
   logic [1:0] rsp_visibility;
   int         fail_count, pending, box_count, idle_cycles, loads_sent;
   int         idle_pct;

   frustum_box_visibility_test_top dut (.*);

   fbvt_scoreboard u_scoreboard (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // watchdog: count cycles in which no word is accepted
   always @(posedge clock) begin
      if (reset || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit) begin
         $display("watchdog expired");
         $display("== FAIL ==");
         $finish;
      end
   end

   // random Q16.16 value: mostly near the origin, sometimes any 32 bits
   function automatic word_type rand_coord();
      if ($urandom_range(9) == 0) return word_type'($urandom);
      return word_type'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
   endfunction

   // present one word and hold it until accepted
   task automatic send_word(logic op, logic [5:0] idx, word_type val,
                            box_type bx, logic rev);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_word_index <= idx;
      req_word_value <= val;
      req_box_x_min <= bx[0]; req_box_x_max <= bx[1];
      req_box_y_min <= bx[2]; req_box_y_max <= bx[3];
      req_box_z_min <= bx[4]; req_box_z_max <= bx[5];
      req_reverse_test <= rev;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op == OP_LOAD) loads_sent++;
   endtask

   task automatic load_word(int idx, word_type val);
      box_type bx;
      foreach (bx[i]) bx[i] = word_type'($urandom);
      send_word(OP_LOAD, 6'(idx), val, bx, 1'($urandom_range(1)));
   endtask

   task automatic test_box(box_type bx, logic rev);
      send_word(OP_TEST, 6'($urandom), word_type'($urandom), bx, rev);
   endtask

   // load a plausible frustum: bounds, planes with Q2.14 normals, vertices
   task automatic load_frustum(bit wild);
      for (int a = 0; a < 3; a++) begin
         load_word(2*a, wild ? word_type'($urandom) : -32'sh000C_0000);
         load_word(2*a+1, wild ? word_type'($urandom) : 32'sh000C_0000);
      end
      for (int p = 0; p < NumPlanes; p++)
         for (int k = 0; k < 4; k++)
            load_word(PlaneBase + 4*p + k, (wild || k == 3) ? rand_coord()
                      : word_type'($urandom_range(0, 32'h8000)) - 32'sh4000);
      for (int v = 0; v < 3*NumVerts; v++)
         load_word(VertBase + v, rand_coord());
   endtask

   // random box, ordered most of the time
   function automatic box_type rand_box();
      box_type bx;
      word_type t;
      for (int a = 0; a < 3; a++) begin
         bx[2*a] = rand_coord();
         bx[2*a+1] = rand_coord();
         if ($urandom_range(7) != 0 && bx[2*a] > bx[2*a+1]) begin
            t = bx[2*a]; bx[2*a] = bx[2*a+1]; bx[2*a+1] = t;
         end
      end
      return bx;
   endfunction

   initial begin
      box_type bx;
      int phase;
      reset = 1; start = 0; req_op = OP_TEST; req_word_index = '0;
      req_word_value = '0; req_reverse_test = 0;
      req_box_x_min = '0; req_box_x_max = '0; req_box_y_min = '0;
      req_box_y_max = '0; req_box_z_min = '0; req_box_z_max = '0;
      idle_pct = 0; loads_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: every word written before any box, extremes of every field
      load_frustum(0);
      load_word(40, 32'sh7FFF_FFFF);   // index out of range: dropped
      load_word(63, 32'sh8000_0000);
      foreach (bx[i]) bx[i] = 0;
      test_box(bx, 0);                 // degenerate box at origin
      foreach (bx[i]) bx[i] = i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      test_box(bx, 1);                 // box covering everything
      foreach (bx[i]) bx[i] = i[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      test_box(bx, 1);                 // min above max
      foreach (bx[i]) bx[i] = i[0] ? 32'sh0001_0000 : -32'sh0001_0000;
      test_box(bx, 0);
      test_box(bx, 1);
      bx[0] = 32'sh000C_0000; bx[1] = 32'sh0010_0000;
      test_box(bx, 1);                 // touches the bound
      bx[0] = 32'sh000C_0001;
      test_box(bx, 0);                 // just beyond the bound
      load_word(PlaneBase, 32'sh7FFF_FFFF);
      load_word(PlaneBase + 1, 32'sh8000_0000);
      test_box(rand_box(), 1);
      load_frustum(0);

      // random phases: no idling, then 49 percent, then 8
      for (phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 0 : (phase == 1) ? 49 : 8;
         for (int n = 0; n < 150; n++) begin
            if ($urandom_range(39) == 0) load_frustum($urandom_range(3) == 0);
            else if ($urandom_range(9) == 0)
               load_word($urandom_range(0, 63), word_type'($urandom));
            else test_box(rand_box(), $urandom_range(3) != 0);
         end
         // hold off until every outstanding result has come back
         start <= 1'b0;
         while (pending != 0) @(posedge clock);
      end

      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Tested %0d boxes with %0d frustum loads over three idling phases.",
               box_count, loads_sent);
      if (fail_count == 0 && pending == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
